/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the motor command decoder.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/umcd_pkg.sv */
// Shared types, constants and helper functions of the motor command decoder.
// No dependencies.
`default_nettype none
package umcd_pkg;

  localparam int QUEUE_SLOTS = 8;
  localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CNT_W = (PTR_W > 3) ? PTR_W : 3;
  localparam int CNT_X = CNT_W + 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0] byte_t;

  localparam byte_t CH_P     = 8'h50;
  localparam byte_t CH_LO_A  = 8'h61;
  localparam byte_t CH_LO_P  = 8'h70;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_RESET = 8'h58;
  localparam logic [9:0] DUTY_STEP = 10'd69;

  typedef enum logic [1:0] {
    K_GOOD    = 2'd0,
    K_FRAME   = 2'd1,
    K_OVERRUN = 2'd2,
    K_DRAIN   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DRAIN   = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_IGNORE  = 3'd2,
    ST_FRAME   = 3'd3,
    ST_OVERRUN = 3'd4
  } status_t;

  typedef struct packed {
    logic  en;
    ptr_t  addr;
    byte_t data;
  } wr_t;

  typedef struct packed {
    logic en;
    ptr_t addr;
  } rd_t;

  typedef struct packed {
    logic pop;
    logic exec;
  } back_ctl_t;

  function automatic logic is_digit(input byte_t b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_letter(input byte_t b);
    return (b >= CH_LO_A) && (b <= CH_LO_P);
  endfunction

  function automatic logic is_command(input byte_t b);
    return is_letter(b) || is_digit(b) || (b == CH_P);
  endfunction

  function automatic ptr_t next_slot(input ptr_t p);
    return (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage
`default_nettype wire

/* src/umcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module umcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/umcd_front.sv */
// Front end: classifies received bytes and pushes commands into the ring.
// Depends on umcd_pkg.
`default_nettype none
module umcd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                offer_en,
  input  wire umcd_pkg::byte_t     offer_byte,
  input  wire umcd_pkg::ptr_t      tail,
  output      logic                is_cmd,
  output      umcd_pkg::ptr_t      head,
  output      umcd_pkg::wr_t       wr
);

  logic full;

  always_comb begin
    is_cmd  = umcd_pkg::is_command(offer_byte);
    // one slot stays free so that full and empty differ
    full    = (umcd_pkg::next_slot(head) == tail);
    wr.en   = offer_en && is_cmd && !full;
    wr.addr = head;
    wr.data = offer_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (wr.en) begin
      head <= umcd_pkg::next_slot(head);
    end
  end

endmodule
`default_nettype wire

/* src/umcd_back.sv */
// Back end: pops the oldest command from the ring and executes it.
// Depends on umcd_pkg.
`default_nettype none
module umcd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire umcd_pkg::back_ctl_t  ctl,
  input  wire umcd_pkg::byte_t      rd_data,
  output      umcd_pkg::rd_t        rd,
  output      umcd_pkg::ptr_t       tail,
  output      logic                 applied,
  output      logic [3:0]           motor_bits,
  output      logic [9:0]           duty_value,
  output      logic                 heartbeat_level
);

  umcd_pkg::byte_t prev_cmd;
  logic            skip;

  always_comb begin
    rd.en   = ctl.pop;
    rd.addr = tail;
    // repeats are dropped, except heartbeat and speed commands
    skip    = (rd_data == prev_cmd) && (rd_data != umcd_pkg::CH_P) &&
              !umcd_pkg::is_digit(rd_data);
    applied = ctl.exec && !skip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail            <= '0;
      prev_cmd        <= umcd_pkg::CH_RESET;
      heartbeat_level <= 1'b0;
      motor_bits      <= 4'd0;
      duty_value      <= 10'd0;
    end else begin
      if (ctl.pop) begin
        tail <= umcd_pkg::next_slot(tail);
      end
      if (applied) begin
        prev_cmd <= rd_data;
        if (rd_data == umcd_pkg::CH_P) begin
          heartbeat_level <= !heartbeat_level;
        end else if (umcd_pkg::is_letter(rd_data)) begin
          // 'a' is 0x61, so the pattern is the low nibble minus one
          motor_bits <= rd_data[3:0] - 4'd1;
        end else if (umcd_pkg::is_digit(rd_data)) begin
          duty_value <= {6'd0, rd_data[3:0]} * umcd_pkg::DUTY_STEP;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/uart_motor_command_decoder_unit.sv */
// Top level of the UART motor command decoder: sequencer, ring RAM, result.
// Depends on umcd_pkg, umcd_ram, umcd_front, umcd_back, assert_macros.svh.
//
//  channel   | handshake      | payload
//  ----------+----------------+---------------------------------------------
//  event in  | start / busy   | kind, first_byte, second_byte
//  result    | done (strobe)  | rx_status, command_applied, motor_pattern,
//            |                | pwm_duty, heartbeat, queue_count
//
// An event is taken when start is high and busy is low; one result follows.
// Framing error or drain of an empty queue: result in the cycle after the transfer.
// Good byte: state PUSH1, then the result. Overrun: PUSH1, then PUSH2 (one ring write per byte,
// single write port). Drain: POP, then EXEC (registered RAM read, then execute).
// Synchronous reset clears pointers and motor state; the ring needs no clearing.
// done is high for one cycle; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"
module uart_motor_command_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output      logic       busy,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] first_byte,
  input  wire logic [7:0] second_byte,
  output      logic       done,
  output      logic [2:0] rx_status,
  output      logic       command_applied,
  output      logic [3:0] motor_pattern,
  output      logic [9:0] pwm_duty,
  output      logic       heartbeat,
  output      logic [2:0] queue_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH1,
    S_PUSH2,
    S_POP,
    S_EXEC
  } state_t;

  state_t                state;
  umcd_pkg::kind_t       kind_q;
  umcd_pkg::byte_t       byte1;
  umcd_pkg::byte_t       byte2;
  umcd_pkg::status_t     status;
  logic                  applied_q;

  logic                  offer_en;
  umcd_pkg::byte_t       offer_byte;
  logic                  is_cmd;
  umcd_pkg::ptr_t        head;
  umcd_pkg::ptr_t        tail;
  umcd_pkg::wr_t         wr;
  umcd_pkg::rd_t         rd;
  umcd_pkg::back_ctl_t   ctl;
  umcd_pkg::byte_t       rd_data;
  logic                  back_applied;
  logic                  empty;
  logic [umcd_pkg::CNT_W:0] head_x;
  logic [umcd_pkg::CNT_W:0] tail_x;
  logic [umcd_pkg::CNT_W:0] len_x;

  umcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .offer_en   (offer_en),
    .offer_byte (offer_byte),
    .tail       (tail),
    .is_cmd     (is_cmd),
    .head       (head),
    .wr         (wr)
  );

  umcd_ram #(
    .WIDTH (8),
    .DEPTH (umcd_pkg::QUEUE_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rd_data)
  );

  umcd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .rd_data         (rd_data),
    .rd              (rd),
    .tail            (tail),
    .applied         (back_applied),
    .motor_bits      (motor_pattern),
    .duty_value      (pwm_duty),
    .heartbeat_level (heartbeat)
  );

  always_comb begin
    busy       = (state != S_IDLE);
    offer_en   = (state == S_PUSH1) || (state == S_PUSH2);
    offer_byte = (state == S_PUSH2) ? byte2 : byte1;
    ctl.pop    = (state == S_POP);
    ctl.exec   = (state == S_EXEC);
    empty      = (head == tail);
    head_x     = umcd_pkg::CNT_X'(head);
    tail_x     = umcd_pkg::CNT_X'(tail);
    if (head >= tail) begin
      len_x = head_x - tail_x;
    end else begin
      len_x = head_x + umcd_pkg::CNT_X'(umcd_pkg::QUEUE_SLOTS) - tail_x;
    end
    queue_count     = len_x[2:0];
    rx_status       = status;
    command_applied = applied_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      status    <= umcd_pkg::ST_DRAIN;
      applied_q <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind_q <= umcd_pkg::kind_t'(kind);
            byte1  <= first_byte;
            byte2  <= second_byte;
            unique case (umcd_pkg::kind_t'(kind))
              umcd_pkg::K_GOOD, umcd_pkg::K_OVERRUN: begin
                state <= S_PUSH1;
              end
              umcd_pkg::K_FRAME: begin
                status    <= umcd_pkg::ST_FRAME;
                applied_q <= 1'b0;
                done      <= 1'b1;
              end
              umcd_pkg::K_DRAIN: begin
                if (empty) begin
                  status    <= umcd_pkg::ST_DRAIN;
                  applied_q <= 1'b0;
                  done      <= 1'b1;
                end else begin
                  state <= S_POP;
                end
              end
            endcase
          end
        end
        S_PUSH1: begin
          if (kind_q == umcd_pkg::K_OVERRUN) begin
            state <= S_PUSH2;
          end else begin
            // a command dropped on a full ring still reports accepted
            status    <= is_cmd ? umcd_pkg::ST_ACCEPT : umcd_pkg::ST_IGNORE;
            applied_q <= 1'b0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_PUSH2: begin
          status    <= umcd_pkg::ST_OVERRUN;
          applied_q <= 1'b0;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_POP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          status    <= umcd_pkg::ST_DRAIN;
          applied_q <= back_applied;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_read_then_exec, clk, rst, rd.en, state == S_EXEC)
  `ASSERT_NOW(a_no_overwrite, clk, rst, wr.en, umcd_pkg::next_slot(head) != tail)
  `ASSERT_NOW(a_applied_on_drain, clk, rst, done && command_applied, rx_status == umcd_pkg::ST_DRAIN)

endmodule
`default_nettype wire

/* sim/uart_motor_command_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for uart_motor_command_decoder_unit: directed and random UART events with
// random start gaps; each done strobe is checked against a local model of the ring.
// Depends on umcd_pkg and the decoder RTL.
module uart_motor_command_decoder_unit_tb;

  typedef struct {
    umcd_pkg::kind_t kind;
    umcd_pkg::byte_t b1;
    umcd_pkg::byte_t b2;
    int              gap;
  } rx_event_t;

  typedef struct {
    umcd_pkg::status_t status;
    logic              applied;
    logic [3:0]        motor;
    logic [9:0]        duty;
    logic              hb;
    logic [2:0]        count;
  } decode_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] kind = umcd_pkg::K_GOOD;
  logic [7:0] first_byte = 8'h00;
  logic [7:0] second_byte = 8'h00;
  logic       busy;
  logic       done;
  logic [2:0] rx_status;
  logic       command_applied;
  logic [3:0] motor_pattern;
  logic [9:0] pwm_duty;
  logic       heartbeat;
  logic [2:0] queue_count;

  rx_event_t       rx_events[$];
  decode_result_t  pending_results[$];
  rx_event_t       cur_ev;
  bit              loaded;
  int              gap_left;
  int              n_total;
  int              n_accepted;
  int              n_errors;
  int              gap_mode;
  umcd_pkg::byte_t last_pick = umcd_pkg::CH_P;

  // model of the command ring and the motor outputs
  umcd_pkg::byte_t ring[umcd_pkg::QUEUE_SLOTS];
  int              wr_idx;
  int              rd_idx;
  umcd_pkg::byte_t prev_cmd;
  logic            hb_lvl;
  logic [3:0]      motor_lvl;
  logic [9:0]      duty_lvl;

  always #10 clk = ~clk;

  uart_motor_command_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .first_byte(first_byte),
    .second_byte(second_byte),
    .done(done),
    .rx_status(rx_status),
    .command_applied(command_applied),
    .motor_pattern(motor_pattern),
    .pwm_duty(pwm_duty),
    .heartbeat(heartbeat),
    .queue_count(queue_count)
  );

  function automatic bit digit_byte(umcd_pkg::byte_t b);
    return b >= umcd_pkg::CH_ZERO && b <= umcd_pkg::CH_NINE;
  endfunction

  function automatic bit cmd_byte(umcd_pkg::byte_t b);
    return (b >= umcd_pkg::CH_LO_A && b <= umcd_pkg::CH_LO_P) || digit_byte(b) ||
           b == umcd_pkg::CH_P;
  endfunction

  function automatic int ring_next(int i);
    return (i + 1 >= umcd_pkg::QUEUE_SLOTS) ? 0 : i + 1;
  endfunction

  // full ring drops the byte but it still counts as accepted
  function automatic bit ring_push(umcd_pkg::byte_t b);
    if (!cmd_byte(b)) return 1'b0;
    if (ring_next(wr_idx) != rd_idx) begin
      ring[wr_idx] = b;
      wr_idx = ring_next(wr_idx);
    end
    return 1'b1;
  endfunction

  // repeats are skipped except heartbeat toggle and speed digits
  function automatic logic run_cmd(umcd_pkg::byte_t c);
    if (c == prev_cmd && c != umcd_pkg::CH_P && !digit_byte(c)) return 1'b0;
    prev_cmd = c;
    if (c == umcd_pkg::CH_P) hb_lvl = ~hb_lvl;
    else if (c >= umcd_pkg::CH_LO_A && c <= umcd_pkg::CH_LO_P)
      motor_lvl = 4'(c - umcd_pkg::CH_LO_A);
    else duty_lvl = 10'(c - umcd_pkg::CH_ZERO) * umcd_pkg::DUTY_STEP;
    return 1'b1;
  endfunction

  task automatic decode_event(rx_event_t ev);
    decode_result_t  r;
    umcd_pkg::byte_t c;
    r.applied = 1'b0;
    case (ev.kind)
      umcd_pkg::K_GOOD:
        r.status = ring_push(ev.b1) ? umcd_pkg::ST_ACCEPT : umcd_pkg::ST_IGNORE;
      umcd_pkg::K_FRAME: r.status = umcd_pkg::ST_FRAME;
      umcd_pkg::K_OVERRUN: begin
        void'(ring_push(ev.b1));
        void'(ring_push(ev.b2));
        r.status = umcd_pkg::ST_OVERRUN;
      end
      default: begin
        r.status = umcd_pkg::ST_DRAIN;
        if (wr_idx != rd_idx) begin
          c = ring[rd_idx];
          rd_idx = ring_next(rd_idx);
          r.applied = run_cmd(c);
        end
      end
    endcase
    r.motor = motor_lvl;
    r.duty = duty_lvl;
    r.hb = hb_lvl;
    r.count = 3'((wr_idx - rd_idx + umcd_pkg::QUEUE_SLOTS) % umcd_pkg::QUEUE_SLOTS);
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(string msg);
    if (n_errors < 40) $display("%0t ns: %s", $time, msg);
    n_errors++;
  endtask

  function automatic int draw_gap();
    case (gap_mode)
      0: return 0;
      1: return $urandom_range(0, 15);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  // mostly command characters, with repeats, near misses and raw bytes
  function automatic umcd_pkg::byte_t pick_byte();
    umcd_pkg::byte_t near_miss[7] = '{8'h60, 8'h71, 8'h2F, 8'h3A, 8'h4F, 8'h51,
                                      umcd_pkg::CH_RESET};
    int sel;
    sel = $urandom_range(0, 99);
    if (sel >= 63 && sel < 78) return last_pick;
    if (sel < 35)
      last_pick = umcd_pkg::CH_LO_A + umcd_pkg::byte_t'($urandom_range(0, 15));
    else if (sel < 55)
      last_pick = umcd_pkg::CH_ZERO + umcd_pkg::byte_t'($urandom_range(0, 9));
    else if (sel < 63) last_pick = umcd_pkg::CH_P;
    else if (sel < 86) last_pick = near_miss[$urandom_range(0, 6)];
    else last_pick = umcd_pkg::byte_t'($urandom_range(0, 255));
    return last_pick;
  endfunction

  task automatic add_event(umcd_pkg::kind_t k, umcd_pkg::byte_t a, umcd_pkg::byte_t b);
    rx_event_t ev;
    ev.kind = k;
    ev.b1 = a;
    ev.b2 = b;
    ev.gap = draw_gap();
    rx_events.push_back(ev);
  endtask

  // driver: holds start until the transfer, then loads the next event after its gap
  always @(posedge clk) begin
    bit go;
    go = start;
    if (rst) begin
      go = 1'b0;
      loaded = 1'b0;
      gap_left = 0;
      wr_idx = 0;
      rd_idx = 0;
      prev_cmd = umcd_pkg::CH_RESET;
      hb_lvl = 1'b0;
      motor_lvl = 4'd0;
      duty_lvl = 10'd0;
    end else begin
      if (start && !busy) begin
        decode_event(cur_ev);
        n_accepted++;
        go = 1'b0;
      end
      if (!go && !loaded && rx_events.size() != 0) begin
        cur_ev = rx_events.pop_front();
        gap_left = cur_ev.gap;
        loaded = 1'b1;
      end
      if (!go && loaded) begin
        if (gap_left == 0) begin
          go = 1'b1;
          loaded = 1'b0;
          kind <= cur_ev.kind;
          first_byte <= cur_ev.b1;
          second_byte <= cur_ev.b2;
        end else begin
          gap_left--;
        end
      end
    end
    start <= go;
  end

  // monitor
  always @(posedge clk) begin
    decode_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, rx_status %0d", rx_status));
      end else begin
        want = pending_results.pop_front();
        if (rx_status != want.status)
          report_mismatch($sformatf("rx_status got %0d, want %0d", rx_status, want.status));
        if (command_applied != want.applied)
          report_mismatch($sformatf("command_applied got %0d, want %0d",
                                    command_applied, want.applied));
        if (motor_pattern != want.motor)
          report_mismatch($sformatf("motor_pattern got %0d, want %0d",
                                    motor_pattern, want.motor));
        if (pwm_duty != want.duty)
          report_mismatch($sformatf("pwm_duty got %0d, want %0d", pwm_duty, want.duty));
        if (heartbeat != want.hb)
          report_mismatch($sformatf("heartbeat got %0d, want %0d", heartbeat, want.hb));
        if (queue_count != want.count)
          report_mismatch($sformatf("queue_count got %0d, want %0d", queue_count, want.count));
      end
    end
  end

  initial begin
    int              burst_left;
    int              drain_pct;
    int              sel;
    umcd_pkg::kind_t k;
    umcd_pkg::byte_t a;
    umcd_pkg::byte_t b;

    gap_mode = 1;
    add_event(umcd_pkg::K_DRAIN, 8'h00, 8'hFF);       // drain of an empty ring
    add_event(umcd_pkg::K_GOOD, 8'h00, 8'hFF);        // non-command bytes
    add_event(umcd_pkg::K_GOOD, 8'hFF, 8'h00);
    // framing error drops a command byte
    add_event(umcd_pkg::K_FRAME, umcd_pkg::CH_LO_A, umcd_pkg::CH_LO_A);
    add_event(umcd_pkg::K_GOOD, umcd_pkg::CH_LO_A, 8'h00);
    add_event(umcd_pkg::K_GOOD, umcd_pkg::CH_LO_A, 8'h00);      // repeat, skipped on drain
    add_event(umcd_pkg::K_GOOD, umcd_pkg::CH_LO_P, 8'h00);
    add_event(umcd_pkg::K_GOOD, umcd_pkg::CH_P, 8'h00);
    add_event(umcd_pkg::K_GOOD, umcd_pkg::CH_P, 8'h00);         // heartbeat toggles twice
    add_event(umcd_pkg::K_GOOD, umcd_pkg::CH_ZERO, 8'h00);
    add_event(umcd_pkg::K_GOOD, umcd_pkg::CH_NINE, 8'h00);      // ring now full
    add_event(umcd_pkg::K_GOOD, umcd_pkg::CH_NINE, 8'h00);      // dropped, still accepted
    add_event(umcd_pkg::K_OVERRUN, umcd_pkg::CH_RESET, umcd_pkg::CH_ZERO + 8'd5);
    repeat (8) add_event(umcd_pkg::K_DRAIN, 8'h00, 8'h00);
    add_event(umcd_pkg::K_OVERRUN, 8'h60, 8'h71);     // both just outside the letter range
    add_event(umcd_pkg::K_OVERRUN, umcd_pkg::CH_LO_A + 8'd2, umcd_pkg::CH_LO_A + 8'd2);
    add_event(umcd_pkg::K_DRAIN, 8'h00, 8'h00);
    add_event(umcd_pkg::K_DRAIN, 8'h00, 8'h00);

    burst_left = 0;
    drain_pct = 30;
    while (rx_events.size() < 1150) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 60);
        drain_pct = $urandom_range(10, 60);
        gap_mode = $urandom_range(0, 2);
      end
      burst_left--;
      sel = $urandom_range(0, 99);
      if (sel < drain_pct) k = umcd_pkg::K_DRAIN;
      else if (sel < drain_pct + 6) k = umcd_pkg::K_FRAME;
      else if (sel < drain_pct + 18) k = umcd_pkg::K_OVERRUN;
      else k = umcd_pkg::K_GOOD;
      if (k == umcd_pkg::K_DRAIN || k == umcd_pkg::K_FRAME)
        a = umcd_pkg::byte_t'($urandom_range(0, 255));
      else a = pick_byte();
      if (k == umcd_pkg::K_OVERRUN) b = pick_byte();
      else b = umcd_pkg::byte_t'($urandom_range(0, 255));
      add_event(k, a, b);
    end
    n_total = rx_events.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (n_accepted < n_total || pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("uart_motor_command_decoder_unit verification clean");
    end else begin
      $display("uart_motor_command_decoder_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("uart_motor_command_decoder_unit verification failed");
    $finish;
  end

endmodule
